FILE: sv/anemometer_pulse_timer_defines.svh
// Assertion macros for the anemometer pulse timer.
// Used by the top level; no other dependencies.
`ifndef ANEMOMETER_PULSE_TIMER_DEFINES_SVH
`define ANEMOMETER_PULSE_TIMER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define APT_ASSERT_NOW(lbl, ante, cons, msg)
`define APT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/apt_pkg.sv
// Shared widths, reset constants and result structs for the pulse timer.
// No dependencies; imported by every module of the block.
package apt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int PHASE_W  = 2;

  localparam logic [TIME_W-1:0] CALIB_END_RESET = 32'h0010_0000;

  // Timebase and pulse counter results
  typedef struct packed {
    logic [TIME_W-1:0] ext_time;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] interval;
    logic              fell;
  } tb_res_t;

  // Calibration machine results
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  pulses;
    logic [TIME_W-1:0]  duration;
  } cal_res_t;

  // One complete result word
  typedef struct packed {
    tb_res_t  tb;
    cal_res_t cal;
  } result_t;

endpackage

FILE: sv/apt_timebase.sv
// Timer extension to 32 bits, falling-edge detect, pulse count and interval.
// Depends on apt_pkg.
module apt_timebase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [apt_pkg::SAMPLE_W-1:0] timer_sample,
  input  logic                         pulse_level,
  output apt_pkg::tb_res_t             res
);
  import apt_pkg::*;

  logic [TIME_W-1:0] time_ext;
  logic              last_level;
  logic [TIME_W-1:0] edge_count;
  logic [TIME_W-1:0] last_edge_time;
  logic [TIME_W-1:0] edge_interval;

  logic [TIME_W-SAMPLE_W-1:0] upper_next;
  logic [TIME_W-1:0]          time_ext_next;
  logic                       fell;
  logic [TIME_W-1:0]          edge_count_next;
  logic [TIME_W-1:0]          edge_interval_next;

  // Carry into the upper half when the sample's top bit wraps from 1 to 0
  always_comb begin
    upper_next = time_ext[TIME_W-1:SAMPLE_W]
               + (TIME_W-SAMPLE_W)'(time_ext[SAMPLE_W-1] & ~timer_sample[SAMPLE_W-1]);
    time_ext_next = {upper_next, timer_sample};
    fell = last_level & ~pulse_level;
    edge_count_next    = fell ? edge_count + TIME_W'(1) : edge_count;
    edge_interval_next = fell ? time_ext_next - last_edge_time : edge_interval;
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ext       <= '0;
      last_level     <= 1'b0;
      edge_count     <= '0;
      last_edge_time <= '0;
      edge_interval  <= '0;
    end else if (accept) begin
      time_ext      <= time_ext_next;
      last_level    <= pulse_level;
      edge_count    <= edge_count_next;
      edge_interval <= edge_interval_next;
      if (fell) begin
        last_edge_time <= time_ext_next;
      end
    end
  end

  assign res.ext_time = time_ext_next;
  assign res.total    = edge_count_next;
  assign res.interval = edge_interval_next;
  assign res.fell     = fell;

endmodule

FILE: sv/apt_calib.sv
// Calibration machine: idle, armed, counting over a configurable window.
// Depends on apt_pkg.
module apt_calib (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       calib_request,
  input  logic                       fell,
  input  logic [apt_pkg::TIME_W-1:0] ext_time,
  input  logic [apt_pkg::TIME_W-1:0] end_time,
  output apt_pkg::cal_res_t          res
);
  import apt_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    IDLE     = 2'd0,
    ARMED    = 2'd1,
    COUNTING = 2'd2
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  phase_t            phase_req;
  logic [TIME_W-1:0] cal_count;
  logic [TIME_W-1:0] cal_count_next;
  logic [TIME_W-1:0] cal_time;
  logic [TIME_W-1:0] cal_time_next;
  logic [TIME_W-1:0] elapsed;

  // A request re-arms first; then a falling edge moves the machine
  always_comb begin
    phase_req      = calib_request ? ARMED : phase;
    phase_next     = phase_req;
    cal_count_next = cal_count;
    cal_time_next  = cal_time;
    elapsed        = ext_time - cal_time;
    if (fell) begin
      case (phase_req)
        ARMED: begin
          cal_time_next  = ext_time;
          cal_count_next = '0;
          phase_next     = COUNTING;
        end
        COUNTING: begin
          cal_count_next = cal_count + TIME_W'(1);
          if (elapsed > end_time) begin
            cal_time_next = elapsed;
            phase_next    = IDLE;
          end
        end
        default: begin
          phase_next = phase_req;
        end
      endcase
    end
  end

  // Hold state between accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= IDLE;
      cal_count <= '0;
      cal_time  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      cal_count <= cal_count_next;
      cal_time  <= cal_time_next;
    end
  end

  assign res.phase    = phase_next;
  assign res.pulses   = cal_count_next;
  assign res.duration = cal_time_next;

endmodule

FILE: sv/apt_skid.sv
// Result register with a skid entry so input accepts while output stalls.
// Depends on apt_pkg.
module apt_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  apt_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output apt_pkg::result_t out_data
);
  import apt_pkg::*;

  result_t main_data;
  logic    main_valid;
  result_t skid_data;
  logic    skid_valid;
  logic    main_free;

  assign main_free = ~main_valid | ~out_stall;

  // Refill the result register from the skid entry first, then from input
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

FILE: sv/anemometer_pulse_timer.sv
// Anemometer pulse timer: one result word per input word.
// An accepted word's result is registered, into the skid entry while the output stalls.
// Throughput: 1 word per cycle while the output is not stalled; a skid entry takes one
// more word during an output stall, then in_stall holds until that entry drains.
// Reset (rst, synchronous): clears all counters, the calibration machine to idle,
// and sets the calibration window limit to 0x00100000.
`include "anemometer_pulse_timer_defines.svh"
module anemometer_pulse_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [apt_pkg::TIME_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [apt_pkg::SAMPLE_W-1:0]  timer_sample,
  input  logic                          pulse_level,
  input  logic                          calib_request,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [apt_pkg::TIME_W-1:0]    extended_time,
  output logic [apt_pkg::TIME_W-1:0]    pulse_total,
  output logic [apt_pkg::TIME_W-1:0]    pulse_interval,
  output logic                          new_pulse,
  output logic [apt_pkg::PHASE_W-1:0]   calib_phase,
  output logic [apt_pkg::TIME_W-1:0]    calib_pulses,
  output logic [apt_pkg::TIME_W-1:0]    calib_time
);
  import apt_pkg::*;

  logic              in_accept;
  logic [TIME_W-1:0] window_limit;
  tb_res_t           tb_res;
  cal_res_t          cal_res;
  result_t           res_next;
  result_t           res_out;
  logic              buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~in_stall;

  // Hold the calibration window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= CALIB_END_RESET;
    end else if (cfg_write) begin
      window_limit <= cfg_data;
    end
  end

  apt_timebase u_timebase (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .timer_sample (timer_sample),
    .pulse_level  (pulse_level),
    .res          (tb_res)
  );

  apt_calib u_calib (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .calib_request (calib_request),
    .fell          (tb_res.fell),
    .ext_time      (tb_res.ext_time),
    .end_time      (window_limit),
    .res           (cal_res)
  );

  assign res_next.tb  = tb_res;
  assign res_next.cal = cal_res;

  apt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (res_next),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  // Unpack the result word onto the ports
  assign extended_time  = res_out.tb.ext_time;
  assign pulse_total    = res_out.tb.total;
  assign pulse_interval = res_out.tb.interval;
  assign new_pulse      = res_out.tb.fell;
  assign calib_phase    = res_out.cal.phase;
  assign calib_pulses   = res_out.cal.pulses;
  assign calib_time     = res_out.cal.duration;

  `APT_ASSERT_NOW(a_skid_implies_main, buf_full, out_valid, "skid entry full with empty result register")
  `APT_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid, "accepted word produced no result")
  `APT_ASSERT_NOW(a_fell_level_low, in_accept && tb_res.fell, !pulse_level, "falling edge with high level")

endmodule
